[hw/rtl/bom_pkg.sv]
// ============================================================================
// bom_pkg: shared types and constants of the binary octagon opening
// Payload words, configuration register codes, window geometry and the
// 21-point octagon element used by both morphology passes.
// ============================================================================
`default_nettype none

package bom_pkg;

  // Window geometry: 5x5 square, centre two rows and two columns in.
  localparam int unsigned WIN        = 5;
  localparam int unsigned HALF       = WIN / 2;
  localparam int unsigned SPAN       = 2 * HALF;
  localparam int unsigned LINE_W     = WIN - 1;

  // Frame end: the result path trails the input by two window half-spans,
  // so the final item sits SPAN rows below the frame, at column SPAN-1.
  localparam int unsigned DRAIN_ROWS = SPAN;
  localparam int unsigned END_COL    = SPAN - 1;

  // Position widths: rows run up to height+DRAIN_ROWS and go negative
  // by up to SPAN+1 for the trailing passes.
  localparam int unsigned DIM_W      = 10;
  localparam int unsigned IN_ROW_W   = DIM_W + 1;
  localparam int unsigned ROW_W      = DIM_W + 2;

  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [7:0]       PIX_ON     = 8'd255;
  localparam logic [7:0]       PIX_OFF    = 8'd0;
  localparam logic [7:0]       THRESH_RST = 8'd128;
  localparam logic [DIM_W-1:0] DIM_RST    = 10'd512;
  localparam logic [DIM_W-1:0] DIM_MIN    = 10'd5;

  // Octagon element over a window flattened as bit (age*WIN + row);
  // the four corners are dropped, leaving 21 points.
  localparam logic [WIN*WIN-1:0] OCT_MASK = 25'b0111_0_111111111111111_0111_0;

  typedef logic signed [ROW_W-1:0] srow_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       flush;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       last_pixel;
  } pix_out_t;

endpackage

`default_nettype wire

[hw/rtl/bom_ram.sv]
// ============================================================================
// bom_ram: simple dual-port RAM
// One write port, one read port with registered read data held while the
// read enable is low.
// ============================================================================
`default_nettype none

module bom_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/bom_stage.sv]
// ============================================================================
// bom_stage: line buffer and 5x5 window of one morphology pass
// Keeps the four previous rows per column, shifts a five-row column into
// the window per word and masks window bits that fall outside the frame.
// ============================================================================
`default_nettype none

module bom_stage #(
  parameter int unsigned MAX_WIDTH = 512
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       adv_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]               rd_col_i,
  input  logic                                       wr_valid_i,
  input  logic                                       wr_bit_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]               wr_col_i,
  input  logic signed [bom_pkg::ROW_W-1:0]           ctr_row_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]               ctr_col_i,
  input  logic [$clog2(MAX_WIDTH):0]                 width_i,
  input  logic [bom_pkg::DIM_W-1:0]                  height_i,
  output logic [bom_pkg::WIN*bom_pkg::WIN-1:0]       covered_o
);

  import bom_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned CCW   = COL_W + 2;

  typedef logic signed [CCW-1:0] scol_t;

  logic [LINE_W-1:0]          line_rd;
  logic [LINE_W-1:0]          line_wr;
  logic [WIN-1:0]             stack;
  logic [WIN-1:0][WIN-1:0]    win_q;    // [age][row], row 0 is the newest
  logic [WIN-1:0][WIN-1:0]    bound;
  logic [WIN-1:0]             row_ok;
  logic [WIN-1:0]             col_ok;
  srow_t                      row_pos [WIN];
  scol_t                      col_pos [WIN];

  // Column stack: new bit on top of the four stored rows; store it back
  // with the oldest row dropped.
  assign stack   = {line_rd, wr_bit_i};
  assign line_wr = {line_rd[LINE_W-2:0], wr_bit_i};

  bom_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_valid_i & adv_i),
    .waddr_i (wr_col_i),
    .wdata_i (line_wr),
    .re_i    (adv_i),
    .raddr_i (rd_col_i),
    .rdata_o (line_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (wr_valid_i && adv_i) begin
      win_q <= {win_q[WIN-2:0], stack};
    end
  end

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      row_pos[i] = ctr_row_i + srow_t'(HALF) - srow_t'(i);
      row_ok[i]  = (row_pos[i] >= 0) &&
                   (row_pos[i] < srow_t'({{(ROW_W-DIM_W){1'b0}}, height_i}));
    end
    for (int k = 0; k < WIN; k++) begin
      col_pos[k] = scol_t'({2'b00, ctr_col_i}) + scol_t'(HALF) - scol_t'(k);
      col_ok[k]  = (col_pos[k] >= 0) && (col_pos[k] < scol_t'({1'b0, width_i}));
    end
    for (int k = 0; k < WIN; k++) begin
      for (int i = 0; i < WIN; i++) begin
        bound[k][i] = row_ok[i] & col_ok[k];
      end
    end
  end

  assign covered_o = win_q & bound;

endmodule

`default_nettype wire

[hw/rtl/binary_opening_octagon_5x5_top.sv]
// ============================================================================
// binary_opening_octagon_5x5_top: binary opening with a 5x5 octagon
// Threshold, erode and dilate a raster pixel stream with line buffers.
// ============================================================================
// The block takes one grey pixel word per clock, binarizes it against the
// threshold, erodes the binary map with a 21-point octagon (5x5 square
// without corners) and dilates the result with the same element, treating
// everything outside the frame as background. Each accepted word passes
// through four register stages, and the block sustains one word per clock
// as long as the output is taken. Results trail the input by 4*W+4 words
// (W the clamped width): a frame takes W*H pixel words followed by 4*W+4
// flush words, and the word that yields the final pixel (last_pixel set)
// ends the frame. Two line memories of MAX_WIDTH x 4 bits, each read and
// written once per word, hold the previous rows; they need no clearing
// after reset. Writing the width or height restarts the frame.
`default_nettype none

module binary_opening_octagon_5x5_top #(
  parameter int unsigned MAX_WIDTH = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bom_pkg::pix_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bom_pkg::pix_out_t               out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bom_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bom_pkg::DIM_W-1:0]       cfg_data_i
);

  import bom_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = COL_W + 1;

  // Configuration
  logic [7:0]          thr_q;
  logic [DIM_W-1:0]    width_q;
  logic [DIM_W-1:0]    height_q;
  logic [WW-1:0]       w_eff;
  logic [DIM_W-1:0]    h_eff;
  logic                geom_wr;

  // Input position within the extended frame (frame plus drain)
  logic [IN_ROW_W-1:0] in_row_q;
  logic [COL_W-1:0]    in_col_q;
  logic                frame_end;
  logic                row_end;

  // Pipeline control
  logic                adv;
  logic                accept;
  logic                v1_q, v2_q, v3_q;
  logic                out_valid_q;

  // Stage 1: registered input word
  logic [7:0]          pix1_q;
  logic                flush1_q;
  logic [IN_ROW_W-1:0] row1_q;
  logic [COL_W-1:0]    col1_q;
  srow_t               row1_s;
  logic                bin_bit;
  srow_t               e_row1, o_row1;
  logic [COL_W-1:0]    e_col1, o_col1;

  // Stage 2: erosion centre
  srow_t               e_row2_q, o_row2_q;
  logic [COL_W-1:0]    e_col2_q, o_col2_q;
  logic [WIN*WIN-1:0]  cov_bin;
  logic                ero_bit;

  // Stage 3: dilation centre
  srow_t               o_row3_q;
  logic [COL_W-1:0]    o_col3_q;
  logic [WIN*WIN-1:0]  cov_ero;
  logic                dil_bit;
  logic                o_in;
  logic                o_last;

  pix_out_t            out_data_q;

  // --------------------------------------------------------------------------
  // Configuration registers; geometry writes restart the frame.
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign geom_wr     = cfg_valid_i &&
                       (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THRESH_RST;
      width_q  <= DIM_RST;
      height_q <= DIM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: thr_q    <= cfg_data_i[7:0];
        CFG_WIDTH:     width_q  <= cfg_data_i;
        CFG_HEIGHT:    height_q <= cfg_data_i;
        default:       ;  // drop writes to unknown registers
      endcase
    end
  end

  // Clamp the width to the line memory depth and both sides to the window.
  always_comb begin
    if (width_q < DIM_MIN) begin
      w_eff = WW'(DIM_MIN);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    h_eff = (height_q < DIM_MIN) ? DIM_MIN : height_q;
  end

  // --------------------------------------------------------------------------
  // Handshake: every stage advances together whenever the output register
  // is free or being drained; bubbles travel as cleared valid bits.
  // --------------------------------------------------------------------------
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // --------------------------------------------------------------------------
  // Input position: walk the frame plus drain rows, wrap at frame end.
  // --------------------------------------------------------------------------
  assign frame_end = (in_row_q == IN_ROW_W'(h_eff) + IN_ROW_W'(DRAIN_ROWS)) &&
                     (in_col_q == COL_W'(END_COL));
  assign row_end   = (WW'(in_col_q) + WW'(1)) == w_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q <= '0;
      in_col_q <= '0;
    end else begin
      priority if (geom_wr) begin
        in_row_q <= '0;
        in_col_q <= '0;
      end else if (accept) begin
        if (frame_end) begin
          in_row_q <= '0;
          in_col_q <= '0;
        end else if (row_end) begin
          in_row_q <= in_row_q + IN_ROW_W'(1);
          in_col_q <= '0;
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline valid bits and the output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q && o_in;
    end
  end

  // Payload registers: load only with a valid word moving in.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q   <= in_data_i.pixel_in;
      flush1_q <= in_data_i.flush;
      row1_q   <= in_row_q;
      col1_q   <= in_col_q;
    end
    if (adv && v1_q) begin
      e_row2_q <= e_row1;
      e_col2_q <= e_col1;
      o_row2_q <= o_row1;
      o_col2_q <= o_col1;
    end
    if (adv && v2_q) begin
      o_row3_q <= o_row2_q;
      o_col3_q <= o_col2_q;
    end
    if (adv && v3_q) begin
      out_data_q.pixel_out  <= dil_bit ? PIX_ON : PIX_OFF;
      out_data_q.last_pixel <= o_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: binarize; flush words and drain rows count as background.
  // Work out the erosion centre (HALF rows and columns back) and the
  // dilation centre (SPAN back), wrapping into the previous row.
  // --------------------------------------------------------------------------
  assign row1_s  = srow_t'({1'b0, row1_q});
  assign bin_bit = (row1_q < IN_ROW_W'(h_eff)) && !flush1_q && (pix1_q >= thr_q);

  always_comb begin
    if (col1_q >= COL_W'(HALF)) begin
      e_row1 = row1_s - srow_t'(HALF);
      e_col1 = col1_q - COL_W'(HALF);
    end else begin
      e_row1 = row1_s - srow_t'(HALF + 1);
      e_col1 = COL_W'(WW'(col1_q) + w_eff - WW'(HALF));
    end
    if (col1_q >= COL_W'(SPAN)) begin
      o_row1 = row1_s - srow_t'(SPAN);
      o_col1 = col1_q - COL_W'(SPAN);
    end else begin
      o_row1 = row1_s - srow_t'(SPAN + 1);
      o_col1 = COL_W'(WW'(col1_q) + w_eff - WW'(SPAN));
    end
  end

  // Binary pass: read the column's stored rows as the word enters stage 1,
  // write them back with the new bit as it leaves.
  bom_stage #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_bin_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .rd_col_i   (in_col_q),
    .wr_valid_i (v1_q),
    .wr_bit_i   (bin_bit),
    .wr_col_i   (col1_q),
    .ctr_row_i  (e_row2_q),
    .ctr_col_i  (e_col2_q),
    .width_i    (w_eff),
    .height_i   (h_eff),
    .covered_o  (cov_bin)
  );

  // --------------------------------------------------------------------------
  // Stage 2: erode. Any element point off the frame reads as zero, which
  // also clears the result for centres outside the frame.
  // --------------------------------------------------------------------------
  assign ero_bit = &(cov_bin | ~OCT_MASK);

  bom_stage #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ero_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .rd_col_i   (e_col1),
    .wr_valid_i (v2_q),
    .wr_bit_i   (ero_bit),
    .wr_col_i   (e_col2_q),
    .ctr_row_i  (o_row3_q),
    .ctr_col_i  (o_col3_q),
    .width_i    (w_eff),
    .height_i   (h_eff),
    .covered_o  (cov_ero)
  );

  // --------------------------------------------------------------------------
  // Stage 3: dilate, emit only for centres inside the frame, flag the
  // bottom-right pixel.
  // --------------------------------------------------------------------------
  assign dil_bit = |(cov_ero & OCT_MASK);
  assign o_in    = (o_row3_q >= 0) &&
                   (o_row3_q < srow_t'({{(ROW_W-DIM_W){1'b0}}, h_eff}));
  assign o_last  = (o_row3_q == srow_t'({{(ROW_W-DIM_W){1'b0}}, h_eff}) - srow_t'(1)) &&
                   ((WW'(o_col3_q) + WW'(1)) == w_eff);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // Input position stays inside the extended frame.
  a_pos_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WW'(in_col_q) < w_eff) &&
    (in_row_q <= IN_ROW_W'(h_eff) + IN_ROW_W'(DRAIN_ROWS)))
    else $error("input position left the extended frame");

  // A stall freezes every stage: no word is lost or duplicated.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({v1_q, v2_q, v3_q}))
    else $error("pipeline moved during a stall");

  // Results are pure black or white.
  a_out_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.pixel_out == PIX_ON || out_data_q.pixel_out == PIX_OFF))
    else $error("result pixel is neither background nor foreground");
`endif

endmodule

`default_nettype wire
